FILE: rtl/srtu_pkg.sv
// shared types and constants for the sort and deduplicate block
package srtu_pkg;

    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int MAX_ITEMS_DEF = 64;

    // result request from the sequencer to the output register
    typedef struct packed {
        logic               valid;
        logic [DATA_W-1:0]  value;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } emit_t;

    // outcome of the shared compare unit
    typedef struct packed {
        logic gt;
        logic ne;
    } cmp_t;

endpackage

FILE: rtl/srtu_cmp.sv
// shared signed compare unit used by insertion, counting and emission
module srtu_cmp (
    input  logic [srtu_pkg::DATA_W-1:0] a,
    input  logic [srtu_pkg::DATA_W-1:0] b,
    output srtu_pkg::cmp_t              res
);

    always_comb begin
        res.gt = $signed(a) > $signed(b);
        res.ne = a != b;
    end

endmodule

FILE: rtl/srtu_store.sv
// value store: one write port, one registered read port with write bypass
module srtu_store #(
    parameter int DEPTH = srtu_pkg::MAX_ITEMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [srtu_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [srtu_pkg::DATA_W-1:0] rd_data
);

    logic [srtu_pkg::DATA_W-1:0] mem [DEPTH];
    logic [srtu_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/srtu_seq.sv
// sequencer: insertion on load, distinct count pass, emission pass
module srtu_seq #(
    parameter int MAX_ITEMS = srtu_pkg::MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [srtu_pkg::DATA_W-1:0] s_ref_value,
    input  logic                        s_set_last,
    input  logic                        out_busy,
    output srtu_pkg::emit_t             emit
);

    localparam int CNT_W = srtu_pkg::COUNT_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               fill_reg, fill_next;
    logic                        ovf_reg, ovf_next;
    logic [srtu_pkg::DATA_W-1:0] val_reg, val_next;
    logic                        last_reg, last_next;
    logic [CW-1:0]               pos_reg, pos_next;
    logic [srtu_pkg::DATA_W-1:0] prev_reg, prev_next;
    logic [CW-1:0]               dist_reg, dist_next;
    logic [CW-1:0]               ecnt_reg, ecnt_next;

    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [srtu_pkg::DATA_W-1:0] wr_data, rd_data;
    logic [srtu_pkg::DATA_W-1:0] cmp_b;
    srtu_pkg::cmp_t              cmp;
    logic                        is_new;
    logic [CW-1:0]               fill_m1;

    srtu_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // during insertion the value in flight is compared, otherwise the previous entry
    assign cmp_b = (state_reg == ST_SHIFT) ? val_reg : prev_reg;

    srtu_cmp u_cmp (
        .a   (rd_data),
        .b   (cmp_b),
        .res (cmp)
    );

    assign fill_m1 = CW'(fill_reg - 1'b1);
    assign is_new  = (pos_reg == '0) || cmp.ne;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        dist_next  = dist_reg;
        ecnt_next  = ecnt_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg[AW-1:0];
        wr_data    = val_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        emit       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (fill_reg < MAX_C) begin
                        val_next  = s_ref_value;
                        last_next = s_set_last;
                        fill_next = CW'(fill_reg + 1'b1);
                        if (fill_reg == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = s_ref_value;
                            if (s_set_last) begin
                                rd_en      = 1'b1;
                                pos_next   = '0;
                                state_next = ST_COUNT;
                            end
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = fill_m1[AW-1:0];
                            pos_next   = fill_reg;
                            state_next = ST_SHIFT;
                        end
                    end else begin
                        ovf_next = 1'b1;
                        if (s_set_last) begin
                            rd_en      = 1'b1;
                            pos_next   = '0;
                            state_next = ST_COUNT;
                        end
                    end
                end
            end

            ST_SHIFT: begin
                // rd_data holds the entry just below pos_reg
                wr_en = 1'b1;
                if ((pos_reg == '0) || !cmp.gt) begin
                    wr_data = val_reg;
                    if (last_reg) begin
                        rd_en      = 1'b1;
                        pos_next   = '0;
                        state_next = ST_COUNT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    wr_data  = rd_data;
                    pos_next = CW'(pos_reg - 1'b1);
                    if (pos_reg > CW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(pos_reg - CW'(2));
                    end
                end
            end

            ST_COUNT: begin
                prev_next = rd_data;
                if (pos_reg == '0) begin
                    dist_next = CW'(1);
                end else if (cmp.ne) begin
                    dist_next = CW'(dist_reg + 1'b1);
                end
                rd_en = 1'b1;
                if (pos_reg == fill_m1) begin
                    pos_next   = '0;
                    ecnt_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    rd_addr  = AW'(pos_reg + 1'b1);
                    pos_next = CW'(pos_reg + 1'b1);
                end
            end

            ST_EMIT: begin
                // hold the read data while a new value waits for the output
                if (!(is_new && out_busy)) begin
                    prev_next = rd_data;
                    if (is_new) begin
                        emit.valid = 1'b1;
                        emit.value = rd_data;
                        emit.last  = (CW'(ecnt_reg + 1'b1) == dist_reg);
                        emit.count = CNT_W'(dist_reg);
                        emit.ovf   = ovf_reg;
                        ecnt_next  = CW'(ecnt_reg + 1'b1);
                    end
                    if (pos_reg == fill_m1) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(pos_reg + 1'b1);
                        pos_next = CW'(pos_reg + 1'b1);
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        last_reg <= last_next;
        pos_reg  <= pos_next;
        prev_reg <= prev_next;
        dist_reg <= dist_next;
        ecnt_reg <= ecnt_next;
    end

endmodule

FILE: rtl/sort_unique_references.sv
// top level: sort and deduplicate sequencer with registered result output
//
// Collects one set of signed 32-bit values, one per request, until the request
// marked set_last, keeps them in ascending order and then returns each distinct
// value once, ascending, with the distinct count and the overflow flag on every
// result. Values past MAX_ITEMS are dropped and flag the set as overflowed.
// Loading is an insertion sort into a store with one write and one read port,
// under one shared compare unit: a value is accepted and the block is then busy
// shifting each stored entry larger than it up one place and then writing it
// (a first value of a set is written at once and a dropped value is not stored).
// After the last request a count pass and then an emission pass each step through
// the N stored values, the emission pass also holding while the result side
// stalls. The last result may still sit in the output register while the first
// request of the next set is accepted.
module sort_unique_references #(
    parameter int MAX_ITEMS = srtu_pkg::MAX_ITEMS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [srtu_pkg::DATA_W-1:0]  s_ref_value,
    input  logic                         s_set_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [srtu_pkg::DATA_W-1:0]  m_unique_value,
    output logic                         m_result_last,
    output logic [srtu_pkg::COUNT_W-1:0] m_distinct_count,
    output logic                         m_overflowed
);

    srtu_pkg::emit_t             emit;
    logic                        out_busy;
    logic                        m_valid_reg;
    logic [srtu_pkg::DATA_W-1:0] value_reg;
    logic                        last_reg;
    logic [srtu_pkg::COUNT_W-1:0] count_reg;
    logic                        ovf_reg;

    srtu_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ref_value (s_ref_value),
        .s_set_last  (s_set_last),
        .out_busy    (out_busy),
        .emit        (emit)
    );

    // a result may be loaded in the cycle the held one is taken
    assign out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            value_reg <= emit.value;
            last_reg  <= emit.last;
            count_reg <= emit.count;
            ovf_reg   <= emit.ovf;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_unique_value   = value_reg;
    assign m_result_last    = last_reg;
    assign m_distinct_count = count_reg;
    assign m_overflowed     = ovf_reg;

endmodule

FILE: sim/sort_unique_references_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sort and deduplicate block
module sort_unique_references_tb;

    localparam int DATA_W       = srtu_pkg::DATA_W;
    localparam int COUNT_W      = srtu_pkg::COUNT_W;
    localparam int SET_CAP      = srtu_pkg::MAX_ITEMS_DEF;
    localparam int DIRECTED_N   = 20;
    localparam int RANDOM_REFS  = 290;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } unique_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              typed;
        unique_t           want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [DATA_W-1:0]   s_ref_value;
    logic                s_set_last;
    logic                m_valid;
    logic                m_ready;
    logic [DATA_W-1:0]   m_unique_value;
    logic                m_result_last;
    logic [COUNT_W-1:0]  m_distinct_count;
    logic                m_overflowed;

    // predictor state: distinct values of the open set, kept ascending
    logic signed [DATA_W-1:0] sorted_distinct[$];
    int unsigned              held_count;
    bit                       set_dropped;
    unique_t                  pending_uniques[$];

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    bit          long_hold_req;
    int unsigned failures;
    int unsigned refs_accepted;
    int unsigned sets_done;
    int unsigned overflow_sets;
    int unsigned results_checked;

    // typed rows are single-value or all-equal sets; the rest go through the predictor
    stim_row_t directed_rows [0:DIRECTED_N-1] = '{
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 7'd1, 1'b0}},
        '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 7'd1, 1'b0}},
        '{32'h7fff_ffff, 1'b1, 1'b1, '{32'h7fff_ffff, 1'b1, 7'd1, 1'b0}},
        '{32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 1'b1, 7'd1, 1'b0}},
        '{32'h0000_0001, 1'b1, 1'b1, '{32'h0000_0001, 1'b1, 7'd1, 1'b0}},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h7fff_ffff, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'hffff_ffff, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b1, 1'b0, '0},
        '{32'h0000_002a, 1'b0, 1'b0, '0},
        '{32'h0000_002a, 1'b0, 1'b0, '0},
        '{32'h0000_002a, 1'b1, 1'b1, '{32'h0000_002a, 1'b1, 7'd1, 1'b0}},
        '{32'h7fff_ffff, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b1, 1'b0, '0},
        '{32'hffff_ffff, 1'b0, 1'b0, '0},
        '{32'hffff_fffe, 1'b1, 1'b0, '0}
    };

    sort_unique_references #(
        .MAX_ITEMS(SET_CAP)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ref_value      (s_ref_value),
        .s_set_last       (s_set_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_unique_value   (m_unique_value),
        .m_result_last    (m_result_last),
        .m_distinct_count (m_distinct_count),
        .m_overflowed     (m_overflowed)
    );

    always #1 aclk = ~aclk;

    // folds one accepted value into the open set, returns the results a closing value releases
    function automatic void absorb_ref(input logic [DATA_W-1:0] v, input logic last,
                                       output unique_t found[$]);
        int      pos;
        unique_t u;
        found = {};
        if (held_count < SET_CAP) begin
            held_count++;
            pos = 0;
            while (pos < sorted_distinct.size() && sorted_distinct[pos] < $signed(v))
                pos++;
            if (pos == sorted_distinct.size() || sorted_distinct[pos] != $signed(v))
                sorted_distinct.insert(pos, $signed(v));
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            foreach (sorted_distinct[k]) begin
                u.value = sorted_distinct[k];
                u.last  = (k == sorted_distinct.size() - 1);
                u.count = COUNT_W'(sorted_distinct.size());
                u.ovf   = set_dropped;
                found.push_back(u);
            end
            sets_done++;
            if (set_dropped)
                overflow_sets++;
            sorted_distinct = {};
            held_count      = 0;
            set_dropped     = 1'b0;
        end
    endfunction

    task automatic push_ref(input logic [DATA_W-1:0] v, input logic last,
                            output unique_t found[$]);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_ref_value <= v;
        s_set_last  <= last;
        do @(posedge aclk); while (!s_ready);
        refs_accepted++;
        absorb_ref(v, last, found);
    endtask

    // half the sets draw from a small pool so duplicates are common
    task automatic send_set(input int n);
        logic [DATA_W-1:0] pool [4];
        bit                narrow;
        logic [DATA_W-1:0] v;
        unique_t           found[$];
        narrow = 1'($urandom_range(1));
        foreach (pool[k])
            pool[k] = $urandom;
        pool[3] = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                default: v = narrow ? pool[2'($urandom_range(3))] : $urandom;
            endcase
            push_ref(v, i == n - 1, found);
            foreach (found[k])
                pending_uniques.push_back(found[k]);
        end
    endtask

    function automatic int random_len();
        if ($urandom_range(99) < 6)
            return $urandom_range(SET_CAP - 4, SET_CAP + 8);
        return $urandom_range(1, 12);
    endfunction

    initial begin : stimulus
        unique_t found[$];
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_ref_value       = '0;
        s_set_last        = 1'b0;
        sender_idle_pct   = 33;
        receiver_idle_pct = 85;
        long_hold_req     = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            push_ref(directed_rows[r].value, directed_rows[r].last, found);
            if (directed_rows[r].typed)
                pending_uniques.push_back(directed_rows[r].want);
            else
                foreach (found[k])
                    pending_uniques.push_back(found[k]);
        end

        // exactly full store, then one past capacity so the closing value is dropped
        send_set(SET_CAP);
        send_set(SET_CAP + 1);
        while (refs_accepted < DIRECTED_N + RANDOM_REFS / 3)
            send_set(random_len());

        sender_idle_pct   = 85;
        receiver_idle_pct = 33;
        while (refs_accepted < DIRECTED_N + 2 * RANDOM_REFS / 3)
            send_set(random_len());

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        // result side stalls long enough for the input to back up
        long_hold_req = 1'b1;
        send_set(10);
        send_set(10);
        while (refs_accepted < DIRECTED_N + RANDOM_REFS)
            send_set(random_len());

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_uniques.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests in %0d sets (%0d over capacity), %0d results checked",
                 refs_accepted, sets_done, overflow_sets, results_checked);
        $display("idle mixes: sender-heavy, receiver-heavy, none, plus one long output stall");
        if (failures == 0)
            $display("sort_unique_references test passed");
        else
            $display("sort_unique_references test failed");
        $finish;
    end

    initial begin : receiver
        int unsigned stall_left;
        bit          hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_taken) begin
                stall_left = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        unique_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_uniques.size() == 0) begin
                $error("result with value %0d arrived with none expected",
                       $signed(m_unique_value));
                failures++;
            end else begin
                want = pending_uniques.pop_front();
                if (m_unique_value !== want.value) begin
                    $error("unique_value: expected %0d, got %0d",
                           $signed(want.value), $signed(m_unique_value));
                    failures++;
                end
                if (m_result_last !== want.last) begin
                    $error("result_last: expected %0d, got %0d", want.last, m_result_last);
                    failures++;
                end
                if (m_distinct_count !== want.count) begin
                    $error("distinct_count: expected %0d, got %0d",
                           want.count, m_distinct_count);
                    failures++;
                end
                if (m_overflowed !== want.ovf) begin
                    $error("overflowed: expected %0d, got %0d", want.ovf, m_overflowed);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        #1000000;
        $display("sort_unique_references test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/srtu_pkg.sv
rtl/srtu_cmp.sv
rtl/srtu_store.sv
rtl/srtu_seq.sv
rtl/sort_unique_references.sv
sim/sort_unique_references_tb.sv
